// ===== hw/rtl/multi_queue_ring_deque_core_assert.svh =====
// Assertion macros for the multi-queue ring deque core.
// Standalone header; expands to concurrent assertions only outside synthesis.
`ifndef MULTI_QUEUE_RING_DEQUE_CORE_ASSERT_SVH
`define MULTI_QUEUE_RING_DEQUE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge out of reset
`define MQRD_ASSERT(lbl, ck, rn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
        else $error("mqrd assertion failed");

// Condition must never be true out of reset
`define MQRD_ASSERT_NEVER(lbl, ck, rn, cond) \
    lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
        else $error("mqrd forbidden condition seen");

`else

`define MQRD_ASSERT(lbl, ck, rn, prop)
`define MQRD_ASSERT_NEVER(lbl, ck, rn, cond)

`endif

`endif

// ===== hw/rtl/mqrd_pkg.sv =====
// Shared types, sizes and index helpers for the multi-queue ring deque.
// No dependencies; used by all modules of the block.
package mqrd_pkg;

    // Block sizing
    localparam int NUM_QUEUES = 32;
    localparam int MAX_DEPTH  = 16;
    localparam int MSG_WIDTH  = 32;

    // Fixed field widths of the stream words
    localparam int ACTION_W   = 2;
    localparam int QID_W      = 5;
    localparam int MESSAGE_W  = 32;
    localparam int STATUS_W   = 2;
    localparam int DATA_OUT_W = 32;
    localparam int COUNT_W    = 5;
    localparam int CAP_W      = 5;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Derived widths
    localparam int QIDX_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int IDX_W   = $clog2(MAX_DEPTH);
    localparam int CNT_W   = $clog2(MAX_DEPTH + 1);
    localparam int SDEPTH  = NUM_QUEUES * MAX_DEPTH;
    localparam int SADDR_W = $clog2(SDEPTH);

    typedef enum logic [ACTION_W-1:0] {
        ACT_SEND_TAIL = 2'd0,
        ACT_SEND_HEAD = 2'd1,
        ACT_RECEIVE   = 2'd2,
        ACT_PEEK      = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Store port request from the queue table
    typedef struct packed {
        logic                 we;
        logic                 re;
        logic [SADDR_W-1:0]   addr;
        logic [MSG_WIDTH-1:0] wdata;
    } store_req_t;

    // Result of one request, before the head word joins it
    typedef struct packed {
        status_t            status;
        logic               data_sel;
        logic [COUNT_W-1:0] count;
    } result_t;

    // Capacity clamped to 1..MAX_DEPTH
    function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
        logic [CNT_W-1:0] res;
        if (cap == '0)
            res = CNT_W'(1);
        else if (32'(cap) > MAX_DEPTH)
            res = CNT_W'(MAX_DEPTH);
        else
            res = CNT_W'(cap);
        return res;
    endfunction

    // Forward step, wraps at or beyond capacity
    function automatic logic [IDX_W-1:0] step_fwd(input logic [IDX_W-1:0] idx,
                                                  input logic [CNT_W-1:0] cap);
        logic [CNT_W:0] nxt;
        nxt = (CNT_W+1)'(idx) + (CNT_W+1)'(1);
        return (nxt >= (CNT_W+1)'(cap)) ? '0 : IDX_W'(nxt);
    endfunction

    // Backward step, lands on capacity-1 from zero or from beyond capacity
    function automatic logic [IDX_W-1:0] step_back(input logic [IDX_W-1:0] idx,
                                                   input logic [CNT_W-1:0] cap);
        logic [CNT_W:0] idx_w;
        idx_w = (CNT_W+1)'(idx);
        if (idx == '0 || idx_w > (CNT_W+1)'(cap))
            return IDX_W'(cap - CNT_W'(1));
        return idx - IDX_W'(1);
    endfunction

    // Flat store address of one slot of one queue
    function automatic logic [SADDR_W-1:0] store_addr(input logic [QIDX_W-1:0] q,
                                                      input logic [IDX_W-1:0] idx);
        return SADDR_W'(int'(q) * MAX_DEPTH + int'(idx));
    endfunction

endpackage

// ===== hw/rtl/mqrd_qstate.sv =====
// Per-queue head/tail/count table and the request decision logic.
// Depends on mqrd_pkg; drives the message store port and the result fields.
module mqrd_qstate
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    input  logic                              advance,
    input  logic [mqrd_pkg::CNT_W-1:0]        cap_eff,
    input  mqrd_pkg::action_t                 action,
    input  logic [mqrd_pkg::QID_W-1:0]        queue_id,
    input  logic [mqrd_pkg::MESSAGE_W-1:0]    message,
    output mqrd_pkg::store_req_t              store_req,
    output mqrd_pkg::result_t                 result
);

    logic [mqrd_pkg::IDX_W-1:0] tail_reg [mqrd_pkg::NUM_QUEUES];
    logic [mqrd_pkg::IDX_W-1:0] head_reg [mqrd_pkg::NUM_QUEUES];
    logic [mqrd_pkg::CNT_W-1:0] fill_reg [mqrd_pkg::NUM_QUEUES];

    logic                         q_ok;
    logic [mqrd_pkg::QIDX_W-1:0]  qsel;
    logic [mqrd_pkg::IDX_W-1:0]   tail_cur;
    logic [mqrd_pkg::IDX_W-1:0]   head_cur;
    logic [mqrd_pkg::CNT_W-1:0]   fill_cur;
    logic                         is_full;
    logic                         is_empty;
    logic [mqrd_pkg::IDX_W-1:0]   head_back;
    logic                         tail_we;
    logic                         head_we;
    logic                         fill_we;
    logic [mqrd_pkg::IDX_W-1:0]   tail_next;
    logic [mqrd_pkg::IDX_W-1:0]   head_next;
    logic [mqrd_pkg::CNT_W-1:0]   fill_next;
    logic                         commit;

    // Look up the addressed queue
    assign q_ok      = 32'(queue_id) < mqrd_pkg::NUM_QUEUES;
    assign qsel      = mqrd_pkg::QIDX_W'(queue_id);
    assign tail_cur  = tail_reg[qsel];
    assign head_cur  = head_reg[qsel];
    assign fill_cur  = fill_reg[qsel];
    assign is_full   = fill_cur >= cap_eff;
    assign is_empty  = fill_cur == '0;
    assign head_back = mqrd_pkg::step_back(head_cur, cap_eff);
    assign commit    = item_valid && advance;

    // Decide the request
    always_comb
    begin
        tail_we         = 1'b0;
        head_we         = 1'b0;
        fill_we         = 1'b0;
        tail_next       = mqrd_pkg::step_fwd(tail_cur, cap_eff);
        head_next       = mqrd_pkg::step_fwd(head_cur, cap_eff);
        fill_next       = fill_cur;
        store_req.we    = 1'b0;
        store_req.re    = 1'b0;
        store_req.addr  = mqrd_pkg::store_addr(qsel, head_cur);
        store_req.wdata = mqrd_pkg::MSG_WIDTH'(message);
        result.status   = mqrd_pkg::ST_OK;
        result.data_sel = 1'b0;
        result.count    = mqrd_pkg::COUNT_W'(fill_cur);

        unique case (action) inside
            mqrd_pkg::ACT_SEND_TAIL, mqrd_pkg::ACT_SEND_HEAD:
            begin
                if (!q_ok || is_full)
                begin
                    result.status = mqrd_pkg::ST_FULL;
                end
                else
                begin
                    fill_we      = 1'b1;
                    fill_next    = fill_cur + mqrd_pkg::CNT_W'(1);
                    store_req.we = commit;
                    if (action == mqrd_pkg::ACT_SEND_TAIL)
                    begin
                        tail_we        = 1'b1;
                        store_req.addr = mqrd_pkg::store_addr(qsel, tail_cur);
                    end
                    else
                    begin
                        head_we        = 1'b1;
                        head_next      = head_back;
                        store_req.addr = mqrd_pkg::store_addr(qsel, head_back);
                    end
                end
            end
            mqrd_pkg::ACT_RECEIVE, mqrd_pkg::ACT_PEEK:
            begin
                if (!q_ok || is_empty)
                begin
                    result.status = mqrd_pkg::ST_EMPTY;
                end
                else
                begin
                    result.data_sel = 1'b1;
                    store_req.re    = commit;
                    if (action == mqrd_pkg::ACT_RECEIVE)
                    begin
                        head_we   = 1'b1;
                        fill_we   = 1'b1;
                        fill_next = fill_cur - mqrd_pkg::CNT_W'(1);
                    end
                end
            end
            default:
            begin
                result.status = mqrd_pkg::ST_EMPTY;
            end
        endcase

        if (!q_ok)
            result.count = '0;
        else
            result.count = mqrd_pkg::COUNT_W'(fill_next);
    end

    // Queue table update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mqrd_pkg::NUM_QUEUES; i++)
            begin
                tail_reg[i] <= '0;
                head_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end
        else if (commit)
        begin
            if (tail_we)
                tail_reg[qsel] <= tail_next;
            if (head_we)
                head_reg[qsel] <= head_next;
            if (fill_we)
                fill_reg[qsel] <= fill_next;
        end
    end

endmodule

// ===== hw/rtl/mqrd_store.sv =====
// Message store: one slot array for all queues, one write or read per cycle.
// Depends on mqrd_pkg; read data is registered and held between reads.
module mqrd_store
(
    input  logic                          clk,
    input  mqrd_pkg::store_req_t          req,
    output logic [mqrd_pkg::MSG_WIDTH-1:0] rd_data
);

    logic [mqrd_pkg::MSG_WIDTH-1:0] mem [mqrd_pkg::SDEPTH];
    logic [mqrd_pkg::MSG_WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (req.we)
            mem[req.addr] <= req.wdata;
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (req.re)
            rd_data_reg <= mem[req.addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/multi_queue_ring_deque_core.sv =====
// Multi-queue ring deque: a bank of ring-buffer message queues, addressed per
// word, that take send-to-tail, send-to-head, receive and peek requests. One
// request word is accepted every clock while the result register is free or
// being taken; its result passes the input register, then the result register
// with the store read, and is held there until taken. The single-port message
// store, written or read once per request, sets that one-word-per-clock rate.
// Full and empty are reported in the result status rather than by stalling;
// the input stalls only while a result is held. No clearing pass after reset.
// Depends on mqrd_pkg, mqrd_qstate, mqrd_store and the assertion header.
`include "multi_queue_ring_deque_core_assert.svh"

module multi_queue_ring_deque_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    // capacity register
    input  logic                               cfg_we,
    input  logic [mqrd_pkg::CAP_W-1:0]         cfg_wdata,
    // request words
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [mqrd_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // queue_id[4:0], message[36:5]
    input  logic [mqrd_pkg::ACTION_W-1:0]      s_axis_tuser,  // action[1:0]
    // result words
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [mqrd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // data_out[31:0], count_now[36:32]
    output logic [mqrd_pkg::STATUS_W-1:0]      m_axis_tuser   // status[1:0]
);

    localparam int MSG_LSB = mqrd_pkg::QID_W;
    localparam int MSG_MSB = mqrd_pkg::QID_W + mqrd_pkg::MESSAGE_W - 1;
    localparam int PAD_W   = mqrd_pkg::OUT_DATA_W - mqrd_pkg::DATA_OUT_W - mqrd_pkg::COUNT_W;

    logic [mqrd_pkg::CAP_W-1:0]       cap_reg;
    logic [mqrd_pkg::CNT_W-1:0]       cap_eff;

    logic                             in_valid_reg;
    mqrd_pkg::action_t                in_action_reg;
    logic [mqrd_pkg::QID_W-1:0]       in_qid_reg;
    logic [mqrd_pkg::MESSAGE_W-1:0]   in_msg_reg;

    logic                             out_valid_reg;
    mqrd_pkg::result_t                out_res_reg;

    logic                             advance;
    mqrd_pkg::store_req_t             store_req;
    mqrd_pkg::result_t                result;
    logic [mqrd_pkg::MSG_WIDTH-1:0]   rd_data;
    logic [mqrd_pkg::DATA_OUT_W-1:0]  data_out;

    // Pipeline moves when the result register is free or being taken
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign cap_eff       = mqrd_pkg::eff_cap(cap_reg);

    // Capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= mqrd_pkg::CAP_RESET;
        else if (cfg_we)
            cap_reg <= cfg_wdata;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_action_reg <= mqrd_pkg::action_t'(s_axis_tuser);
            in_qid_reg    <= s_axis_tdata[mqrd_pkg::QID_W-1:0];
            in_msg_reg    <= s_axis_tdata[MSG_MSB:MSG_LSB];
        end
    end

    // Queue table and decision
    mqrd_qstate u_qstate
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_valid_reg),
        .advance    (advance),
        .cap_eff    (cap_eff),
        .action     (in_action_reg),
        .queue_id   (in_qid_reg),
        .message    (in_msg_reg),
        .store_req  (store_req),
        .result     (result)
    );

    // Message store
    mqrd_store u_store
    (
        .clk     (clk),
        .req     (store_req),
        .rd_data (rd_data)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
            out_res_reg <= result;
    end

    // Output word
    assign data_out      = out_res_reg.data_sel ? mqrd_pkg::DATA_OUT_W'(rd_data) : '0;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.status;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_res_reg.count, data_out};

    // Checks
    `MQRD_ASSERT(a_no_data_on_reject, clk, rst_n,
        out_valid_reg && out_res_reg.status != mqrd_pkg::ST_OK |-> !out_res_reg.data_sel)
    `MQRD_ASSERT(a_count_bound, clk, rst_n,
        out_valid_reg |-> 32'(out_res_reg.count) <= mqrd_pkg::MAX_DEPTH)
    `MQRD_ASSERT(a_item_reaches_output, clk, rst_n,
        in_valid_reg && advance |=> out_valid_reg)
    `MQRD_ASSERT_NEVER(a_store_single_port, clk, rst_n,
        store_req.we && store_req.re)

endmodule
